FILE: hdl/stcp_pkg.sv
// Shared types and codes for the switch/timer command processor.
`default_nettype none

package stcp_pkg;

  localparam int unsigned SwOutW    = 5;   // switch pins on the result channel
  localparam int unsigned GroupMax  = 8;   // widest group count the block supports
  localparam int unsigned ReplyBytes = 7;

  localparam logic [7:0] CmdInit  = 8'hF0;
  localparam logic [7:0] CmdIdAck = 8'h01;
  localparam logic [7:0] GcClear  = 8'h00;
  localparam logic [7:0] GcSetId  = 8'h01;
  localparam logic [7:0] GcReadId = 8'h02;
  localparam logic [7:0] ClrOnSel  = 8'h01;
  localparam logic [7:0] ClrOffSel = 8'h00;
  localparam logic [7:0] ByteOff  = 8'hFF;

  // low nibble of the command byte
  typedef enum logic [3:0] {
    OpAck    = 4'h1,
    OpFull   = 4'h2,
    OpDetail = 4'h3,
    OpSet    = 4'h4
  } op_e;

  // query / set sub-commands
  typedef enum logic [7:0] {
    SubSwitch = 8'h01,
    SubOn     = 8'h03,
    SubOff    = 8'h04,
    SubClock  = 8'h05,
    SubClear  = 8'h06
  } sub_e;

  typedef enum logic [1:0] {
    RepNone   = 2'd0,
    RepId     = 2'd1,
    RepFull   = 2'd2,
    RepDetail = 2'd3
  } rep_e;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] group_class;
    logic [7:0] opt_first;
    logic [7:0] opt_second;
    logic [7:0] opt_third;
    logic [7:0] opt_fourth;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        reply_count;
    logic [7:0]        reply_command;
    logic [7:0]        reply_byte_zero;
    logic [7:0]        reply_byte_one;
    logic [7:0]        reply_byte_two;
    logic [7:0]        reply_byte_three;
    logic [7:0]        reply_byte_four;
    logic [7:0]        reply_byte_five;
    logic [7:0]        reply_byte_six;
    logic              restart_repeat;
    logic [SwOutW-1:0] switch_outputs;
  } rsp_t;

  typedef struct packed {
    logic [31:0] device_id_at_power_on;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/stcp_chan_if.sv
// Valid/ready channel interface carrying one payload type.
`default_nettype none

interface stcp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/switch_timer_command_processor_unit.sv
// Switch/timer command processor: command decode, timer table, reply register.
//
// Channels:
//   cmd_i  - one received command per transfer (command, group/class, four options).
//   rsp_o  - exactly one result per command: held reply, restart pulse, switch levels.
//   cfg_i  - device ID write; loads the ID state at once. Always ready.
// Pipeline: a command is registered on acceptance and its table entry is read
//   into the read register; when the command advances, the read-modify-write
//   loads the result register, which then transfers on rsp_o.ready.
// Throughput: one command per cycle while rsp_o is not stalled. The table memory
//   has one write and one read port; a back-to-back command to the same entry
//   takes the previous write through a one-entry bypass.
// Reset: init flag, switches, device ID, group checksums and the reply clear;
//   every table entry reads as all 0xFF with checksum 0 through per-entry valid
//   flops, so no clearing pass is needed and commands are taken right away.
// Stall: while the result register waits on rsp_o.ready, one more command can
//   sit in the input register; cmd_i.ready drops only when both are full.
`default_nettype none

module switch_timer_command_processor_unit #(
  parameter int unsigned GROUPS          = 5,   // 1..8
  parameter int unsigned SLOTS_PER_GROUP = 10   // 1..16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  stcp_chan_if.sink        cmd_i,
  stcp_chan_if.source      rsp_o,
  stcp_chan_if.sink        cfg_i
);
  import stcp_pkg::*;

  localparam int unsigned Depth = GROUPS * SLOTS_PER_GROUP;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic s1_vld_q, rsp_vld_q, adv, in_fire;

  assign adv       = s1_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign cmd_i.ready = !s1_vld_q || adv;
  assign in_fire   = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Input decode and stage-1 registers
  // ---------------------------------------------------------------------------
  cmd_t            in_cmd;
  logic [3:0]      in_g, in_c;
  logic            in_tab;
  logic [IdxW-1:0] in_idx;

  assign in_cmd = cmd_i.data;
  assign in_g   = in_cmd.group_class[7:4];
  assign in_c   = in_cmd.group_class[3:0];
  assign in_tab = (32'(in_g) < GROUPS) && (32'(in_c) < SLOTS_PER_GROUP);
  assign in_idx = in_tab ? IdxW'(32'(in_g) * SLOTS_PER_GROUP + 32'(in_c)) : '0;

  cmd_t            s1_cmd_q;
  logic            s1_tab_q;
  logic [IdxW-1:0] s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= in_cmd;
      s1_tab_q <= in_tab;
      s1_idx_q <= in_idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Timer table: {entry checksum, off min, off hour, on min, on hour}
  // ---------------------------------------------------------------------------
  logic [39:0]     tmem [Depth];
  logic [Depth-1:0] tvld_q;
  logic [39:0]     rd_q;
  logic            rd_vld_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [31:0]     wr_ent;
  logic [7:0]      wr_cs;
  logic            fwd_q;
  logic [39:0]     fwd_data_q;

  assign wr_idx = s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (adv && wr_en) begin
      tmem[wr_idx] <= {wr_cs, wr_ent};
    end
    if (in_fire) begin
      rd_q <= tmem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q   <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (adv && wr_en) begin
        tvld_q[wr_idx] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_q <= tvld_q[in_idx];
        fwd_q    <= adv && wr_en && (wr_idx == in_idx);
      end
    end
  end

  // bypass for a write landing in the same edge as the next read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_data_q <= {wr_cs, wr_ent};
    end
  end

  logic [31:0] ent;
  logic [7:0]  ent_cs;

  always_comb begin
    if (fwd_q) begin
      ent    = fwd_data_q[31:0];
      ent_cs = fwd_data_q[39:32];
    end else if (rd_vld_q) begin
      ent    = rd_q[31:0];
      ent_cs = rd_q[39:32];
    end else begin
      ent    = '1;
      ent_cs = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------------
  logic              init_q, init_d;
  logic [31:0]       id_q, id_d;
  logic [GROUPS-1:0] sw_q, sw_d;
  logic [7:0]        gcs_q [GROUPS];
  logic [7:0]        gcs_d [GROUPS];
  logic [1:0]        cnt_q, cnt_d;
  logic [7:0]        rcmd_q, rcmd_d;
  logic [7:0]        rb_q [ReplyBytes];
  logic [7:0]        rb_d [ReplyBytes];
  logic              rst_rep_q, rst_rep_d;

  // zero-extended views so group indexes never run past the arrays
  logic [GroupMax-1:0] sw_ext;
  logic [7:0]          gcs_ext [GroupMax];

  assign sw_ext = GroupMax'(sw_q);

  for (genvar k = 0; k < GroupMax; k++) begin : g_gcs_ext
    if (k < GROUPS) begin : g_real
      assign gcs_ext[k] = gcs_q[k];
    end else begin : g_pad
      assign gcs_ext[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Command processing
  // ---------------------------------------------------------------------------
  logic [3:0]          g;
  logic                g_ok;
  logic [GroupMax-1:0] sw_ext_d;
  logic [7:0]          gcs_ext_d [GroupMax];
  logic                pair_en, pair_off;
  logic [7:0]          pair_hr, pair_mn;
  logic [7:0]          old_hr, old_mn;
  logic [31:0]         q_ent;

  assign g     = s1_cmd_q.group_class[7:4];
  assign g_ok  = 32'(g) < GROUPS;
  assign q_ent = s1_tab_q ? ent : '0;

  always_comb begin
    init_d    = init_q;
    id_d      = id_q;
    sw_ext_d  = sw_ext;
    cnt_d     = cnt_q;
    rcmd_d    = rcmd_q;
    rb_d      = rb_q;
    rst_rep_d = 1'b0;
    pair_en   = 1'b0;
    pair_off  = 1'b0;
    pair_hr   = s1_cmd_q.opt_second;
    pair_mn   = s1_cmd_q.opt_third;

    if (!init_q && s1_cmd_q.command == CmdInit) begin
      init_d    = 1'b1;
      cnt_d     = RepId;
      rcmd_d    = CmdIdAck;
      rb_d[0]   = '0;
      rb_d[1]   = id_q[7:0];
      rb_d[2]   = id_q[15:8];
      rb_d[3]   = id_q[23:16];
      rb_d[4]   = id_q[31:24];
      rb_d[5]   = '0;
      rb_d[6]   = '0;
      rst_rep_d = 1'b1;
    end else begin
      case (s1_cmd_q.command[3:0])
        OpAck: begin
          if (s1_cmd_q.group_class == GcClear) begin
            cnt_d = RepNone;
          end else if (s1_cmd_q.group_class == GcSetId ||
                       s1_cmd_q.group_class == GcReadId) begin
            if (s1_cmd_q.group_class == GcSetId) begin
              id_d = {s1_cmd_q.opt_fourth, s1_cmd_q.opt_third,
                      s1_cmd_q.opt_second, s1_cmd_q.opt_first};
            end
            cnt_d     = RepId;
            rcmd_d    = s1_cmd_q.command;
            rb_d[0]   = s1_cmd_q.group_class;
            rb_d[1]   = id_d[7:0];
            rb_d[2]   = id_d[15:8];
            rb_d[3]   = id_d[23:16];
            rb_d[4]   = id_d[31:24];
            rb_d[5]   = '0;
            rb_d[6]   = '0;
            rst_rep_d = 1'b1;
          end
        end
        OpFull: begin
          cnt_d   = RepFull;
          rcmd_d  = s1_cmd_q.command;
          rb_d[0] = sw_ext;
          rb_d[1] = '0;
          for (int k = 0; k < 5; k++) begin
            rb_d[k+2] = gcs_ext[k];
          end
          rst_rep_d = 1'b1;
        end
        OpDetail: begin
          cnt_d   = RepDetail;
          rcmd_d  = s1_cmd_q.command;
          rb_d[0] = s1_cmd_q.group_class;
          rb_d[1] = s1_cmd_q.opt_first;
          case (s1_cmd_q.opt_first)
            SubSwitch: begin
              rb_d[2] = {7'd0, g_ok & sw_ext[g[2:0]]};
              rb_d[3] = '0;
            end
            SubOn: begin
              rb_d[2] = q_ent[7:0];
              rb_d[3] = q_ent[15:8];
            end
            SubOff: begin
              rb_d[2] = q_ent[23:16];
              rb_d[3] = q_ent[31:24];
            end
            default: cnt_d = RepNone;
          endcase
          if (cnt_d != RepNone) begin
            rb_d[4] = '0;
            rb_d[5] = '0;
            rb_d[6] = '0;
          end
        end
        OpSet: begin
          if (s1_tab_q) begin
            case ({4'd0, s1_cmd_q.opt_first[3:0]})
              SubSwitch: sw_ext_d[g[2:0]] = (s1_cmd_q.opt_second != 8'd0);
              SubOn:     pair_en = 1'b1;
              SubOff: begin
                pair_en  = 1'b1;
                pair_off = 1'b1;
              end
              SubClock: ;
              SubClear: begin
                pair_hr = ByteOff;
                pair_mn = ByteOff;
                if (s1_cmd_q.opt_second == ClrOnSel) begin
                  pair_en = 1'b1;
                end else if (s1_cmd_q.opt_second == ClrOffSel) begin
                  pair_en  = 1'b1;
                  pair_off = 1'b1;
                end
              end
              default: cnt_d = RepNone;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // read-modify-write of one on/off pair and its checksums
  always_comb begin
    old_hr = pair_off ? ent[23:16] : ent[7:0];
    old_mn = pair_off ? ent[31:24] : ent[15:8];
    wr_en  = pair_en;
    wr_ent = pair_off ? {pair_mn, pair_hr, ent[15:0]} : {ent[31:16], pair_mn, pair_hr};
    wr_cs  = ent_cs ^ old_hr ^ old_mn ^ pair_hr ^ pair_mn;
    gcs_ext_d = gcs_ext;
    if (pair_en) begin
      gcs_ext_d[g[2:0]] = gcs_ext[g[2:0]] ^ ent_cs ^ wr_cs;
    end
  end

  assign sw_d = sw_ext_d[GROUPS-1:0];
  for (genvar k = 0; k < GROUPS; k++) begin : g_gcs_d
    assign gcs_d[k] = gcs_ext_d[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b0;
      id_q      <= '0;
      sw_q      <= '0;
      gcs_q     <= '{default: '0};
      cnt_q     <= RepNone;
      rcmd_q    <= '0;
      rb_q      <= '{default: '0};
      rst_rep_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        init_q    <= init_d;
        sw_q      <= sw_d;
        gcs_q     <= gcs_d;
        cnt_q     <= cnt_d;
        rcmd_q    <= rcmd_d;
        rb_q      <= rb_d;
        rst_rep_q <= rst_rep_d;
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      // a configuration write acts like a power-on load of the ID
      if (cfg_i.valid && cfg_i.ready) begin
        id_q <= cfg_i.data.device_id_at_power_on;
      end else if (adv) begin
        id_q <= id_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  rsp_t rsp;

  always_comb begin
    rsp.reply_count      = cnt_q;
    rsp.reply_command    = rcmd_q;
    rsp.reply_byte_zero  = rb_q[0];
    rsp.reply_byte_one   = rb_q[1];
    rsp.reply_byte_two   = rb_q[2];
    rsp.reply_byte_three = rb_q[3];
    rsp.reply_byte_four  = rb_q[4];
    rsp.reply_byte_five  = rb_q[5];
    rsp.reply_byte_six   = rb_q[6];
    rsp.restart_repeat   = rst_rep_q;
    rsp.switch_outputs   = sw_ext[SwOutW-1:0];
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rst_rep_q |-> (cnt_q == RepId || cnt_q == RepFull))
    else $error("restart pulse with a reply type that never restarts");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && rsp_vld_q && !rsp_o.ready |-> !cmd_i.ready)
    else $error("command taken while both stages are full");

  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(init_q))
    else $error("init flag cleared after being set");

  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && wr_en |=> tvld_q[$past(wr_idx)])
    else $error("table entry written but not marked valid");

endmodule

`default_nettype wire
